// ===== rtl/core/rfq_pkg.sv =====
package rfq_pkg;

  // Defaults for the top-level parameters
  localparam int DEPTH_DEF     = 1024;
  localparam int ELEM_W_DEF    = 32;
  localparam int MAX_BURST_DEF = 64;

  // Fixed field widths of the channels
  localparam int DATA_W  = 32;
  localparam int CMD_W   = 3;
  localparam int CNT_W   = 7;
  localparam int LVL_W   = 10;
  localparam int CAP_REG_W = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 3'd0,
    CMD_GET   = 3'd1,
    CMD_PEEK  = 3'd2,
    CMD_SKIP  = 3'd3,
    CMD_CLEAR = 3'd4
  } rfq_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_BURST
  } rfq_state_t;

  // Result fields known when a result is issued; rd marks a beat whose
  // data comes from the storage read issued in the same cycle.
  typedef struct packed {
    logic             rd;
    logic             valid_res;
    logic             last;
    logic [CNT_W-1:0] done_count;
    logic [LVL_W-1:0] fill_level;
    logic [LVL_W-1:0] free_space;
  } rfq_meta_t;

  typedef struct packed {
    logic [DATA_W-1:0] data_out;
    logic              valid_res;
    logic              last;
    logic [CNT_W-1:0]  done_count;
    logic [LVL_W-1:0]  fill_level;
    logic [LVL_W-1:0]  free_space;
  } rfq_res_t;

endpackage

// ===== rtl/core/rfq_req_if.sv =====
interface rfq_req_if;
  logic                        valid;
  logic                        ready;
  logic [rfq_pkg::CMD_W-1:0]   cmd;
  logic [rfq_pkg::DATA_W-1:0]  data_in;
  logic [rfq_pkg::CNT_W-1:0]   count;

  modport source (output valid, output cmd, output data_in, output count, input ready);
  modport sink   (input valid, input cmd, input data_in, input count, output ready);
endinterface

// ===== rtl/core/rfq_rsp_if.sv =====
interface rfq_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [rfq_pkg::DATA_W-1:0]  data_out;
  logic                        valid_res;
  logic                        last;
  logic [rfq_pkg::CNT_W-1:0]   done_count;
  logic [rfq_pkg::LVL_W-1:0]   fill_level;
  logic [rfq_pkg::LVL_W-1:0]   free_space;

  modport source (output valid, output data_out, output valid_res, output last,
                  output done_count, output fill_level, output free_space, input ready);
  modport sink   (input valid, input data_out, input valid_res, input last,
                  input done_count, input fill_level, input free_space, output ready);
endinterface

// ===== rtl/core/rfq_mem.sv =====
module rfq_mem #(
  parameter int DEPTH         = rfq_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = rfq_pkg::ELEM_W_DEF,
  localparam int PTR_W        = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [PTR_W-1:0]         waddr,
  input  logic [ELEMENT_WIDTH-1:0] wdata,
  input  logic                     re,
  input  logic [PTR_W-1:0]         raddr,
  output logic [ELEMENT_WIDTH-1:0] rdata
);

  logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/rfq_out.sv =====
// Two-entry result queue; the producer reserves a slot before issuing.
module rfq_out (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  rfq_pkg::rfq_res_t push_res,
  input  logic              pop,
  output rfq_pkg::rfq_res_t front,
  output logic              not_empty,
  output logic [1:0]        occ
);

  rfq_pkg::rfq_res_t slot [2];
  logic              wr_idx;
  logic              rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= 1'b0;
      rd_idx <= 1'b0;
      occ    <= 2'd0;
    end else begin
      if (push) begin
        wr_idx <= ~wr_idx;
      end
      if (pop) begin
        rd_idx <= ~rd_idx;
      end
      occ <= occ + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_idx] <= push_res;
    end
  end

  assign front     = slot[rd_idx];
  assign not_empty = (occ != 2'd0);

endmodule

// ===== rtl/core/rfq_ctrl.sv =====
// Pointer/fill bookkeeping and burst sequencer around the storage memory.
module rfq_ctrl #(
  parameter int DEPTH         = rfq_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = rfq_pkg::ELEM_W_DEF,
  parameter int MAX_BURST     = rfq_pkg::MAX_BURST_DEF,
  localparam int PTR_W        = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rfq_pkg::CAP_REG_W-1:0]   cfg_wdata,
  rfq_req_if.sink                         req,
  input  logic                            room,
  output logic                            mem_we,
  output logic [PTR_W-1:0]                mem_waddr,
  output logic [ELEMENT_WIDTH-1:0]        mem_wdata,
  output logic                            mem_re,
  output logic [PTR_W-1:0]                mem_raddr,
  output logic                            res_valid,
  output rfq_pkg::rfq_meta_t              res_meta
);

  localparam int CAP_W = $clog2(DEPTH + 1);
  localparam int CNT_W = rfq_pkg::CNT_W;
  localparam int LVL_W = rfq_pkg::LVL_W;
  localparam int SUM_W = ((CAP_W > CNT_W) ? CAP_W : CNT_W) + 1;

  rfq_pkg::rfq_state_t state, state_next;
  logic [CAP_W-1:0]    cap;
  logic [PTR_W-1:0]    wp, wp_next;
  logic [PTR_W-1:0]    rp, rp_next;
  logic [PTR_W-1:0]    fill, fill_next;
  logic [PTR_W-1:0]    cur, cur_next;
  logic [CNT_W-1:0]    left, left_next;
  logic [CNT_W-1:0]    total, total_next;
  logic                is_get, is_get_next;

  logic                issue;
  rfq_pkg::rfq_meta_t  meta;
  logic                accept;
  logic [CNT_W-1:0]    cnt_sat;
  logic [CNT_W-1:0]    n;
  logic                full;
  logic [SUM_W-1:0]    skip_sum;
  logic [PTR_W-1:0]    rp_skip;
  logic [31:0]         cap_wide;
  logic [31:0]         cap_clamp;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p,
                                               input logic [CAP_W-1:0] c);
    logic [CAP_W-1:0] s;
    s = CAP_W'(p) + CAP_W'(1);
    return (s == c) ? '0 : PTR_W'(s);
  endfunction

  function automatic logic [LVL_W-1:0] free_of(input logic [PTR_W-1:0] f,
                                               input logic [CAP_W-1:0] c);
    return LVL_W'(c - CAP_W'(1) - CAP_W'(f));
  endfunction

  assign accept   = req.valid && req.ready;
  assign req.ready = (state == rfq_pkg::ST_IDLE) && room;

  assign cnt_sat  = (req.count > CNT_W'(MAX_BURST)) ? CNT_W'(MAX_BURST) : req.count;
  assign n        = (32'(cnt_sat) < 32'(fill)) ? cnt_sat : CNT_W'(fill);
  assign full     = (CAP_W'(fill) == cap - CAP_W'(1));
  assign skip_sum = SUM_W'(rp) + SUM_W'(n);
  assign rp_skip  = (skip_sum >= SUM_W'(cap)) ? PTR_W'(skip_sum - SUM_W'(cap))
                                              : PTR_W'(skip_sum);

  assign cap_wide  = 32'(cfg_wdata);
  assign cap_clamp = (cap_wide < 32'd2) ? 32'd2 :
                     (cap_wide > 32'(DEPTH)) ? 32'(DEPTH) : cap_wide;

  assign mem_wdata = ELEMENT_WIDTH'(req.data_in);
  assign mem_waddr = wp;

  always_comb begin
    state_next  = state;
    wp_next     = wp;
    rp_next     = rp;
    fill_next   = fill;
    cur_next    = cur;
    left_next   = left;
    total_next  = total;
    is_get_next = is_get;
    issue       = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = cur;
    meta.rd         = 1'b0;
    meta.valid_res  = 1'b0;
    meta.last       = 1'b1;
    meta.done_count = '0;
    meta.fill_level = LVL_W'(fill);
    meta.free_space = free_of(fill, cap);

    unique case (state)
      rfq_pkg::ST_IDLE: begin
        if (accept) begin
          issue = 1'b1;
          unique case (req.cmd)
            rfq_pkg::CMD_PUT: begin
              if (!full) begin
                mem_we          = 1'b1;
                wp_next         = ptr_inc(wp, cap);
                fill_next       = fill + PTR_W'(1);
                meta.done_count = CNT_W'(1);
                meta.fill_level = LVL_W'(fill_next);
                meta.free_space = free_of(fill_next, cap);
              end
            end
            rfq_pkg::CMD_GET,
            rfq_pkg::CMD_PEEK: begin
              if (n != '0) begin
                is_get_next     = (req.cmd == rfq_pkg::CMD_GET);
                mem_re          = 1'b1;
                mem_raddr       = rp;
                cur_next        = ptr_inc(rp, cap);
                left_next       = n - CNT_W'(1);
                total_next      = n;
                meta.rd         = 1'b1;
                meta.valid_res  = 1'b1;
                meta.last       = (n == CNT_W'(1));
                meta.done_count = n;
                if (is_get_next) begin
                  rp_next   = cur_next;
                  fill_next = fill - PTR_W'(1);
                end
                meta.fill_level = LVL_W'(fill_next);
                meta.free_space = free_of(fill_next, cap);
                if (n != CNT_W'(1)) begin
                  state_next = rfq_pkg::ST_BURST;
                end
              end
            end
            rfq_pkg::CMD_SKIP: begin
              rp_next         = rp_skip;
              fill_next       = fill - PTR_W'(n);
              meta.done_count = n;
              meta.fill_level = LVL_W'(fill_next);
              meta.free_space = free_of(fill_next, cap);
            end
            rfq_pkg::CMD_CLEAR: begin
              wp_next         = '0;
              rp_next         = '0;
              fill_next       = '0;
              meta.fill_level = '0;
              meta.free_space = free_of('0, cap);
            end
            default: begin
            end
          endcase
        end
      end
      rfq_pkg::ST_BURST: begin
        if (room) begin
          issue           = 1'b1;
          mem_re          = 1'b1;
          cur_next        = ptr_inc(cur, cap);
          left_next       = left - CNT_W'(1);
          meta.rd         = 1'b1;
          meta.valid_res  = 1'b1;
          meta.last       = (left == CNT_W'(1));
          meta.done_count = total;
          if (is_get) begin
            rp_next   = cur_next;
            fill_next = fill - PTR_W'(1);
          end
          meta.fill_level = LVL_W'(fill_next);
          meta.free_space = free_of(fill_next, cap);
          if (left == CNT_W'(1)) begin
            state_next = rfq_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = rfq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rfq_pkg::ST_IDLE;
      cap       <= CAP_W'(DEPTH);
      wp        <= '0;
      rp        <= '0;
      fill      <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      res_valid <= issue;
      if (cfg_we) begin
        // a capacity write also restarts both pointers
        cap  <= CAP_W'(cap_clamp);
        wp   <= '0;
        rp   <= '0;
        fill <= '0;
      end else begin
        wp   <= wp_next;
        rp   <= rp_next;
        fill <= fill_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur    <= cur_next;
    left   <= left_next;
    total  <= total_next;
    is_get <= is_get_next;
    if (issue) begin
      res_meta <= meta;
    end
  end

endmodule

// ===== rtl/core/ring_fifo_element_queue_unit.sv =====
// Ring element FIFO that keeps one slot empty. Elements live in a single
// synchronous RAM of DEPTH words (one write and one read port, registered
// read data); the cfg register sets how many slots are in use (clamped to
// 2..DEPTH), so at most capacity-1 elements are held, and a capacity write
// also resets both pointers. Commands: put, get, peek, skip, clear. Put,
// skip, clear and unknown codes give one result beat each, so a stream of
// puts runs at one per cycle while the result queue has room. Get and peek
// of n available elements (count capped at MAX_BURST) give one RAM read and
// one result beat per cycle while the result queue has room, with last on
// the final beat; with nothing available they give one beat with valid_res
// low. The request side stays not-ready for the rest of a multi-element
// burst. Results pass through a registered issue stage that meets the RAM
// read data, then a two-entry result queue; a result is issued only when a
// queue slot is reserved for it, so a stalled consumer just pauses the
// sequencer. The storage has no reset and needs no clearing pass: the
// pointers never reach an entry that was not written.
module ring_fifo_element_queue_unit #(
  parameter int DEPTH         = rfq_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = rfq_pkg::ELEM_W_DEF,
  parameter int MAX_BURST     = rfq_pkg::MAX_BURST_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [rfq_pkg::CAP_REG_W-1:0] cfg_wdata,
  rfq_req_if.sink                       req,
  rfq_rsp_if.source                     rsp
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int DW    = rfq_pkg::DATA_W;

  logic                     mem_we;
  logic [PTR_W-1:0]         mem_waddr;
  logic [ELEMENT_WIDTH-1:0] mem_wdata;
  logic                     mem_re;
  logic [PTR_W-1:0]         mem_raddr;
  logic [ELEMENT_WIDTH-1:0] mem_rdata;

  logic                     res_valid;
  rfq_pkg::rfq_meta_t       res_meta;
  rfq_pkg::rfq_res_t        push_res;
  rfq_pkg::rfq_res_t        front;
  logic                     not_empty;
  logic [1:0]               occ;
  logic                     pop;
  logic [1:0]               reserved;
  logic                     room;

  // Slots already spoken for: queued beats plus the one in the issue stage.
  // A beat leaving this cycle frees one.
  assign pop      = rsp.valid && rsp.ready;
  assign reserved = occ + {1'b0, res_valid};
  assign room     = reserved <= (pop ? 2'd2 : 2'd1);

  rfq_ctrl #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .MAX_BURST     (MAX_BURST)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req),
    .room      (room),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .res_valid (res_valid),
    .res_meta  (res_meta)
  );

  rfq_mem #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // RAM read data joins its beat in the cycle after the read was issued
  always_comb begin
    push_res.data_out   = res_meta.rd ? DW'(mem_rdata) : '0;
    push_res.valid_res  = res_meta.valid_res;
    push_res.last       = res_meta.last;
    push_res.done_count = res_meta.done_count;
    push_res.fill_level = res_meta.fill_level;
    push_res.free_space = res_meta.free_space;
  end

  rfq_out u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_res  (push_res),
    .pop       (pop),
    .front     (front),
    .not_empty (not_empty),
    .occ       (occ)
  );

  assign rsp.valid      = not_empty;
  assign rsp.data_out   = front.data_out;
  assign rsp.valid_res  = front.valid_res;
  assign rsp.last       = front.last;
  assign rsp.done_count = front.done_count;
  assign rsp.fill_level = front.fill_level;
  assign rsp.free_space = front.free_space;

endmodule
